[src/pprd_pkg.sv]
package pprd_pkg;

   localparam int COORD_BITS_DEFAULT = 12;

   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS  = 16;
   localparam int LATENCY    = 11 + SQRT_STEPS + 1 + DIV_STEPS + 1;

   typedef enum logic [2:0] {
      REG_PIXEL_SCALE   = 3'd0,
      REG_HORIZ_RES     = 3'd1,
      REG_VERT_RES      = 3'd2,
      REG_VIEW_DISTANCE = 3'd3,
      REG_BASIS_U       = 3'd4,
      REG_BASIS_V       = 3'd5,
      REG_BASIS_W       = 3'd6
   } reg_index_type;

   localparam logic [23:0] PIXEL_SCALE_RESET   = 24'd65536;
   localparam logic [12:0] HORIZ_RES_RESET     = 13'd640;
   localparam logic [12:0] VERT_RES_RESET      = 13'd480;
   localparam logic [23:0] VIEW_DISTANCE_RESET = 24'd128000;
   localparam logic [59:0] BASIS_U_RESET       = 60'd262144;
   localparam logic [59:0] BASIS_V_RESET       = 60'd274877906944;
   localparam logic [59:0] BASIS_W_RESET       = 60'd288230376151711744;

   typedef struct packed {
      logic [2:0][29:0] mag;
      logic [2:0]       neg;
      logic             deg;
   } side_type;

endpackage

[src/pinhole_primary_ray_direction.sv]
// throughput: one ray per cycle; the whole pipeline holds while the response waits
// the square root takes one result bit per stage and each quotient one bit per stage
// reset: synchronous, active high; clears the valid bits and restores the registers
// to their default camera (scale 1.0, 640x480, distance 500, identity basis)
module pinhole_primary_ray_direction #(
   parameter int COORD_BITS = pprd_pkg::COORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pixel_column, pixel_row, sample_x, sample_y
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // dir_x, dir_y, dir_z
   output logic [47:0] rsp_tdata,
   // degenerate
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CB = (COORD_BITS < 12) ? COORD_BITS : 12;
   localparam logic [11:0] CMASK = 12'((13'd1 << CB) - 13'd1);
   localparam int NST = pprd_pkg::LATENCY;
   localparam int SQN = pprd_pkg::SQRT_STEPS;
   localparam int DVN = pprd_pkg::DIV_STEPS;

   // configuration registers
   logic [23:0] scale_ff;
   logic [12:0] hres_ff, vres_ff;
   logic [23:0] dist_ff;
   logic [59:0] bu_ff, bv_ff, bw_ff;
   pprd_pkg::reg_index_type idx;
   logic wr;

   assign csr_pready = 1'b1;
   assign idx = pprd_pkg::reg_index_type'(csr_paddr[5:3]);
   assign wr  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= pprd_pkg::PIXEL_SCALE_RESET;
         hres_ff  <= pprd_pkg::HORIZ_RES_RESET;
         vres_ff  <= pprd_pkg::VERT_RES_RESET;
         dist_ff  <= pprd_pkg::VIEW_DISTANCE_RESET;
         bu_ff    <= pprd_pkg::BASIS_U_RESET;
         bv_ff    <= pprd_pkg::BASIS_V_RESET;
         bw_ff    <= pprd_pkg::BASIS_W_RESET;
      end else if (wr) begin
         unique case (idx)
            pprd_pkg::REG_PIXEL_SCALE:   scale_ff <= csr_pwdata[23:0];
            pprd_pkg::REG_HORIZ_RES:     hres_ff  <= csr_pwdata[12:0];
            pprd_pkg::REG_VERT_RES:      vres_ff  <= csr_pwdata[12:0];
            pprd_pkg::REG_VIEW_DISTANCE: dist_ff  <= csr_pwdata[23:0];
            pprd_pkg::REG_BASIS_U:       bu_ff    <= csr_pwdata[59:0];
            pprd_pkg::REG_BASIS_V:       bv_ff    <= csr_pwdata[59:0];
            pprd_pkg::REG_BASIS_W:       bw_ff    <= csr_pwdata[59:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         pprd_pkg::REG_PIXEL_SCALE:   csr_prdata = {40'd0, scale_ff};
         pprd_pkg::REG_HORIZ_RES:     csr_prdata = {51'd0, hres_ff};
         pprd_pkg::REG_VERT_RES:      csr_prdata = {51'd0, vres_ff};
         pprd_pkg::REG_VIEW_DISTANCE: csr_prdata = {40'd0, dist_ff};
         pprd_pkg::REG_BASIS_U:       csr_prdata = {4'd0, bu_ff};
         pprd_pkg::REG_BASIS_V:       csr_prdata = {4'd0, bv_ff};
         pprd_pkg::REG_BASIS_W:       csr_prdata = {4'd0, bw_ff};
         default:                     csr_prdata = 64'd0;
      endcase
   end

   // pipeline control
   logic adv;
   logic [NST-1:0] vld_ff, vld_in;
   assign adv        = ~vld_ff[NST-1] | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NST-1];
   assign vld_in     = {vld_ff[NST-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: view plane offsets
   logic [11:0] col, row;
   logic signed [35:0] offx_ff, offy_ff, offx_in, offy_in;
   assign col = req_tdata[11:0] & CMASK;
   assign row = req_tdata[23:12] & CMASK;
   assign offx_in = $signed({8'd0, col, 16'd0}) - $signed({8'd0, hres_ff, 15'd0})
                  + $signed({20'd0, req_tdata[39:24]});
   assign offy_in = $signed({8'd0, row, 16'd0}) - $signed({8'd0, vres_ff, 15'd0})
                  + $signed({20'd0, req_tdata[55:40]});

   // stage 2: scale
   logic signed [24:0] scale_sg;
   logic signed [60:0] px_ff, py_ff;
   assign scale_sg = $signed({1'b0, scale_ff});

   // stage 3: round to q.16, with y negated
   logic signed [60:0] xr, yr;
   logic signed [43:0] x_ff, y_ff;
   assign xr = px_ff + 61'sd32768;
   assign yr = 61'sd32768 - py_ff;

   // stage 4: basis products
   logic signed [2:0][63:0] pu_ff, pv_ff, pw_ff, pu_in, pv_in, pw_in;
   logic signed [24:0] dist_sg;
   assign dist_sg = $signed({1'b0, dist_ff});

   always_comb begin
      logic signed [19:0] ui, vi, wi;
      logic signed [44:0] dw;
      for (int i = 0; i < 3; i++) begin
         ui = $signed(bu_ff[20*i +: 20]);
         vi = $signed(bv_ff[20*i +: 20]);
         wi = $signed(bw_ff[20*i +: 20]);
         pu_in[i] = x_ff * ui;
         pv_in[i] = y_ff * vi;
         dw = dist_sg * wi;
         pw_in[i] = {{11{dw[44]}}, dw, 8'd0};
      end
   end

   // stages 5 to 9: sum, magnitude, maximum, leading one, normalising shift, followed by squaring
   logic signed [2:0][63:0] c_ff;
   logic [2:0][63:0] mag6_ff, mag7_ff, mag8_ff;
   logic [2:0] neg6_ff, neg7_ff, neg8_ff;
   logic [63:0] m_ff;
   logic [5:0] pos_ff, pos_in;
   logic zero_ff;
   pprd_pkg::side_type sd9_ff, sd9_in, sd10_ff;
   logic [2:0][59:0] sq_ff;

   always_comb begin
      pos_in = 6'd0;
      for (int b = 0; b < 64; b++) begin
         if (m_ff[b]) pos_in = 6'(b);
      end
   end

   always_comb begin
      logic [63:0] t;
      sd9_in.neg = neg8_ff;
      sd9_in.deg = zero_ff;
      for (int i = 0; i < 3; i++) begin
         if (pos_ff >= 6'd30) t = mag8_ff[i] >> (pos_ff - 6'd29);
         else                 t = mag8_ff[i] << (6'd29 - pos_ff);
         sd9_in.mag[i] = t[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         offx_ff <= offx_in;
         offy_ff <= offy_in;
         px_ff   <= scale_sg * offx_ff;
         py_ff   <= scale_sg * offy_ff;
         x_ff    <= xr[59:16];
         y_ff    <= yr[59:16];
         pu_ff   <= pu_in;
         pv_ff   <= pv_in;
         pw_ff   <= pw_in;
         for (int i = 0; i < 3; i++) begin
            c_ff[i]    <= pu_ff[i] + pv_ff[i] - pw_ff[i];
            neg6_ff[i] <= c_ff[i][63];
            mag6_ff[i] <= c_ff[i][63] ? 64'(-c_ff[i]) : 64'(c_ff[i]);
            sq_ff[i]   <= sd9_ff.mag[i] * sd9_ff.mag[i];
         end
         mag7_ff <= mag6_ff;
         neg7_ff <= neg6_ff;
         m_ff    <= (mag6_ff[0] > mag6_ff[1])
                  ? ((mag6_ff[0] > mag6_ff[2]) ? mag6_ff[0] : mag6_ff[2])
                  : ((mag6_ff[1] > mag6_ff[2]) ? mag6_ff[1] : mag6_ff[2]);
         mag8_ff <= mag7_ff;
         neg8_ff <= neg7_ff;
         pos_ff  <= pos_in;
         zero_ff <= (m_ff == 64'd0);
         sd9_ff  <= sd9_in;
         sd10_ff <= sd9_ff;
      end
   end

   // stage 11 and square root stages
   logic [61:0] rad_ff [0:SQN];
   logic [32:0] rem_ff [0:SQN];
   logic [30:0] root_ff [0:SQN];
   pprd_pkg::side_type sqs_ff [0:SQN];

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff[0]  <= 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         sqs_ff[0]  <= sd10_ff;
      end
   end

   for (genvar g = 0; g < SQN; g++) begin : g_sqrt
      logic [34:0] trial, test;
      assign trial = {rem_ff[g], rad_ff[g][61:60]};
      assign test  = {2'd0, root_ff[g], 2'b01};
      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[g+1] <= {rad_ff[g][59:0], 2'd0};
            sqs_ff[g+1] <= sqs_ff[g];
            if (trial >= test) begin
               rem_ff[g+1]  <= 33'(trial - test);
               root_ff[g+1] <= {root_ff[g][29:0], 1'b1};
            end else begin
               rem_ff[g+1]  <= trial[32:0];
               root_ff[g+1] <= {root_ff[g][29:0], 1'b0};
            end
         end
      end
   end

   // numerator stage and division stages
   logic [2:0][30:0] drem_ff [0:DVN];
   logic [2:0][15:0] dnum_ff [0:DVN];
   logic [2:0][15:0] q_ff [0:DVN];
   logic [30:0] len_ff [0:DVN];
   logic [2:0] dneg_ff [0:DVN];
   logic ddeg_ff [0:DVN];

   always_ff @(posedge clock) begin
      logic [45:0] n;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            n = {1'b0, sqs_ff[SQN].mag[i], 15'd0} + {16'd0, root_ff[SQN][30:1]};
            drem_ff[0][i] <= {1'b0, n[45:16]};
            dnum_ff[0][i] <= n[15:0];
            q_ff[0][i]    <= '0;
         end
         len_ff[0]  <= root_ff[SQN];
         dneg_ff[0] <= sqs_ff[SQN].neg;
         ddeg_ff[0] <= sqs_ff[SQN].deg;
      end
   end

   for (genvar g = 0; g < DVN; g++) begin : g_div
      always_ff @(posedge clock) begin
         logic [31:0] t;
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               t = {drem_ff[g][i], dnum_ff[g][i][15]};
               dnum_ff[g+1][i] <= {dnum_ff[g][i][14:0], 1'b0};
               if (t >= {1'b0, len_ff[g]}) begin
                  drem_ff[g+1][i] <= 31'(t - {1'b0, len_ff[g]});
                  q_ff[g+1][i]    <= {q_ff[g][i][14:0], 1'b1};
               end else begin
                  drem_ff[g+1][i] <= t[30:0];
                  q_ff[g+1][i]    <= {q_ff[g][i][14:0], 1'b0};
               end
            end
            len_ff[g+1]  <= len_ff[g];
            dneg_ff[g+1] <= dneg_ff[g];
            ddeg_ff[g+1] <= ddeg_ff[g];
         end
      end
   end

   // output stage: sign, saturation and zeroing of degenerate rays
   logic [47:0] out_ff, out_in;
   logic deg_ff;

   always_comb begin
      logic [15:0] q;
      for (int i = 0; i < 3; i++) begin
         q = q_ff[DVN][i];
         if (ddeg_ff[DVN]) begin
            out_in[16*i +: 16] = 16'd0;
         end else if (dneg_ff[DVN][i]) begin
            out_in[16*i +: 16] = (q > 16'd32768) ? 16'h8000 : 16'(-q);
         end else begin
            out_in[16*i +: 16] = (q > 16'd32767) ? 16'h7fff : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
         deg_ff <= ddeg_ff[DVN];
      end
   end

   assign rsp_tdata = out_ff;
   assign rsp_tuser = deg_ff;

   // checks
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 48'd0)
      else $error("degenerate response with nonzero direction");

   a_norm: assert property (@(posedge clock) disable iff (reset)
      vld_ff[8] && !sd9_ff.deg |->
         (sd9_ff.mag[0][29] || sd9_ff.mag[1][29] || sd9_ff.mag[2][29]))
      else $error("normalised magnitudes out of range");

   a_root: assert property (@(posedge clock) disable iff (reset)
      vld_ff[41] && !sqs_ff[SQN].deg |-> root_ff[SQN][30:29] != 2'b00)
      else $error("square root below expected range");

   a_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-2] && !ddeg_ff[DVN] |->
         (drem_ff[DVN][0] < len_ff[DVN]) && (drem_ff[DVN][1] < len_ff[DVN])
         && (drem_ff[DVN][2] < len_ff[DVN]))
      else $error("division remainder not below divisor");

endmodule
